// File: rtl/dtp_pkg.sv
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared types and constants for the disparity to point converter: field
// widths, register indexes and the beat types that move through the cells.
// ----------------------------------------------------------------------------
package dtp_pkg;

	localparam int MAX_IMAGE_SIDE = 4096;

	localparam int COORD_W  = 12;
	localparam int CENTER_W = 16;
	localparam int GAIN_W   = 32;
	localparam int DISP_W   = 8;
	localparam int COLOR_W  = 8;
	localparam int POINT_W  = 32;

	// coordinate scaled to 1/16 pixel
	localparam int SUB_BITS = 4;
	localparam int MAG_W    = CENTER_W;
	localparam int PROD_W   = GAIN_W + MAG_W;
	// dividend after the divide by 16 is folded in as a right shift
	localparam int DVD_W    = PROD_W - SUB_BITS;
	// one quotient bit per cell
	localparam int CELL_COUNT = DVD_W;

	localparam int LANES  = 3;
	localparam int LANE_X = 0;
	localparam int LANE_Y = 1;
	localparam int LANE_Z = 2;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_GAIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_GAIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MIN  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MAX  = 3'd6;

	localparam logic [CENTER_W-1:0] CENTER_X_RST   = 16'd5120;
	localparam logic [CENTER_W-1:0] CENTER_Y_RST   = 16'd3840;
	localparam logic [GAIN_W-1:0]   GAIN_RST       = 32'd65536;
	localparam logic [POINT_W-1:0]  DEPTH_MIN_RST  = 32'd983040;
	localparam logic [POINT_W-1:0]  DEPTH_MAX_RST  = 32'd3932160;

	typedef struct packed {
		logic [CENTER_W-1:0] center_x;
		logic [CENTER_W-1:0] center_y;
		logic [GAIN_W-1:0]   x_gain;
		logic [GAIN_W-1:0]   y_gain;
		logic [GAIN_W-1:0]   depth_gain;
		logic [POINT_W-1:0]  depth_min;
		logic [POINT_W-1:0]  depth_max;
	} cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic [DISP_W-1:0]  disparity;
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
	} pix_t;

	// word holds the dividend bits not yet consumed in its upper part and
	// the quotient bits produced so far in its lower part
	typedef struct packed {
		logic [LANES-1:0][DVD_W-1:0]  word;
		logic [LANES-1:0][DISP_W-1:0] rem;
		logic [DISP_W-1:0]            disp;
		logic                         neg_x;
		logic                         neg_y;
		logic [COLOR_W-1:0]           blue;
		logic [COLOR_W-1:0]           green;
		logic [COLOR_W-1:0]           red;
	} cell_t;

endpackage

// File: rtl/dtp_front.sv
// ----------------------------------------------------------------------------
// dtp_front
// Pixel offset from the principal point, then gain times offset, loaded into
// the x and y words, z gets depth gain. Zero disparity beats are dropped here.
// ----------------------------------------------------------------------------
module dtp_front (
	input  logic           clk,
	input  logic           arst_n,
	input  dtp_pkg::cfg_t  cfg,
	input  logic           up_valid,
	output logic           up_ready,
	input  dtp_pkg::pix_t  up_data,
	output logic           dn_valid,
	input  logic           dn_ready,
	output dtp_pkg::cell_t dn_data
);

	logic [dtp_pkg::COORD_W-1:0]  col_c;
	logic [dtp_pkg::COORD_W-1:0]  row_c;
	logic [dtp_pkg::MAG_W-1:0]    scaled_x;
	logic [dtp_pkg::MAG_W-1:0]    scaled_y;
	logic                         neg_x;
	logic                         neg_y;
	logic [dtp_pkg::MAG_W-1:0]    mag_x;
	logic [dtp_pkg::MAG_W-1:0]    mag_y;

	logic                         valid_s1;
	logic                         ready_s1;
	logic                         neg_x_s1;
	logic                         neg_y_s1;
	logic [dtp_pkg::MAG_W-1:0]    mag_x_s1;
	logic [dtp_pkg::MAG_W-1:0]    mag_y_s1;
	logic [dtp_pkg::DISP_W-1:0]   disp_s1;
	logic [dtp_pkg::COLOR_W-1:0]  blue_s1;
	logic [dtp_pkg::COLOR_W-1:0]  green_s1;
	logic [dtp_pkg::COLOR_W-1:0]  red_s1;

	logic [dtp_pkg::PROD_W-1:0]   prod_x;
	logic [dtp_pkg::PROD_W-1:0]   prod_y;

	logic                         valid_s2;
	logic                         ready_s2;
	dtp_pkg::cell_t               data_s2;

	always_comb begin
		col_c = up_data.column;
		row_c = up_data.row;
		if (32'(up_data.column) >= 32'(dtp_pkg::MAX_IMAGE_SIDE)) begin
			col_c = dtp_pkg::COORD_W'(dtp_pkg::MAX_IMAGE_SIDE - 1);
		end
		if (32'(up_data.row) >= 32'(dtp_pkg::MAX_IMAGE_SIDE)) begin
			row_c = dtp_pkg::COORD_W'(dtp_pkg::MAX_IMAGE_SIDE - 1);
		end
		scaled_x = {col_c, dtp_pkg::SUB_BITS'(0)};
		scaled_y = {row_c, dtp_pkg::SUB_BITS'(0)};
		neg_x = scaled_x < cfg.center_x;
		neg_y = scaled_y < cfg.center_y;
		mag_x = neg_x ? (cfg.center_x - scaled_x) : (scaled_x - cfg.center_x);
		mag_y = neg_y ? (cfg.center_y - scaled_y) : (scaled_y - cfg.center_y);
	end

	assign ready_s2 = !valid_s2 || dn_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign up_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				// no match, nothing to triangulate
				valid_s1 <= up_valid && (up_data.disparity != '0);
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && up_valid) begin
			neg_x_s1 <= neg_x;
			neg_y_s1 <= neg_y;
			mag_x_s1 <= mag_x;
			mag_y_s1 <= mag_y;
			disp_s1  <= up_data.disparity;
			blue_s1  <= up_data.blue;
			green_s1 <= up_data.green;
			red_s1   <= up_data.red;
		end
	end

	assign prod_x = dtp_pkg::PROD_W'(cfg.x_gain) * dtp_pkg::PROD_W'(mag_x_s1);
	assign prod_y = dtp_pkg::PROD_W'(cfg.y_gain) * dtp_pkg::PROD_W'(mag_y_s1);

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			// floor(p / (16 d)) == floor(floor(p / 16) / d)
			data_s2.word[dtp_pkg::LANE_X] <= prod_x[dtp_pkg::PROD_W-1:dtp_pkg::SUB_BITS];
			data_s2.word[dtp_pkg::LANE_Y] <= prod_y[dtp_pkg::PROD_W-1:dtp_pkg::SUB_BITS];
			data_s2.word[dtp_pkg::LANE_Z] <= dtp_pkg::DVD_W'(cfg.depth_gain);
			data_s2.rem   <= '0;
			data_s2.disp  <= disp_s1;
			data_s2.neg_x <= neg_x_s1;
			data_s2.neg_y <= neg_y_s1;
			data_s2.blue  <= blue_s1;
			data_s2.green <= green_s1;
			data_s2.red   <= red_s1;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_data  = data_s2;

endmodule

// File: rtl/dtp_cell.sv
// ----------------------------------------------------------------------------
// dtp_cell
// One restoring division step for the three lanes: pulls the next dividend
// bit into the partial remainder and shifts one quotient bit in.
// ----------------------------------------------------------------------------
module dtp_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  dtp_pkg::cell_t up_data,
	output logic           dn_valid,
	input  logic           dn_ready,
	output dtp_pkg::cell_t dn_data
);

	logic                         valid_q;
	dtp_pkg::cell_t               data_q;
	dtp_pkg::cell_t               step;
	logic [dtp_pkg::DISP_W:0]     trial;
	logic                         fits;

	always_comb begin
		step = up_data;
		trial = '0;
		fits = 1'b0;
		for (int l = 0; l < dtp_pkg::LANES; l++) begin
			trial = {up_data.rem[l], up_data.word[l][dtp_pkg::DVD_W-1]};
			fits = trial >= {1'b0, up_data.disp};
			// remainder stays below the divisor, so eight bits hold it
			step.rem[l] = fits ? dtp_pkg::DISP_W'(trial - {1'b0, up_data.disp})
			                   : trial[dtp_pkg::DISP_W-1:0];
			step.word[l] = {up_data.word[l][dtp_pkg::DVD_W-2:0], fits};
		end
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= step;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

// File: rtl/dtp_back.sv
// ----------------------------------------------------------------------------
// dtp_back
// Applies sign and saturation to the x and y quotients, checks depth against
// the window and holds the result beat in the output register.
// ----------------------------------------------------------------------------
module dtp_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dtp_pkg::cfg_t                      cfg,
	input  logic                               up_valid,
	output logic                               up_ready,
	input  dtp_pkg::cell_t                     up_data,
	output logic                               pt_valid,
	input  logic                               pt_stall,
	output logic signed [dtp_pkg::POINT_W-1:0] point_x,
	output logic signed [dtp_pkg::POINT_W-1:0] point_y,
	output logic        [dtp_pkg::POINT_W-1:0] point_z,
	output logic        [dtp_pkg::COLOR_W-1:0] blue_out,
	output logic        [dtp_pkg::COLOR_W-1:0] green_out,
	output logic        [dtp_pkg::COLOR_W-1:0] red_out
);

	localparam logic [dtp_pkg::DVD_W-1:0] POS_LIMIT =
		dtp_pkg::DVD_W'({1'b0, {(dtp_pkg::POINT_W-1){1'b1}}});
	localparam logic [dtp_pkg::DVD_W-1:0] NEG_LIMIT =
		dtp_pkg::DVD_W'({1'b1, {(dtp_pkg::POINT_W-1){1'b0}}});

	logic                          valid_q;
	logic [dtp_pkg::POINT_W-1:0]   x_val;
	logic [dtp_pkg::POINT_W-1:0]   y_val;
	logic [dtp_pkg::POINT_W-1:0]   z_val;
	logic                          keep;

	function automatic logic [dtp_pkg::POINT_W-1:0] apply_sign(
		input logic [dtp_pkg::DVD_W-1:0] q,
		input logic                      neg
	);
		logic [dtp_pkg::POINT_W-1:0] m;
		if (!neg) begin
			m = (q > POS_LIMIT) ? POS_LIMIT[dtp_pkg::POINT_W-1:0] : q[dtp_pkg::POINT_W-1:0];
			return m;
		end
		m = (q > NEG_LIMIT) ? NEG_LIMIT[dtp_pkg::POINT_W-1:0] : q[dtp_pkg::POINT_W-1:0];
		return dtp_pkg::POINT_W'(0) - m;
	endfunction

	always_comb begin
		x_val = apply_sign(up_data.word[dtp_pkg::LANE_X], up_data.neg_x);
		y_val = apply_sign(up_data.word[dtp_pkg::LANE_Y], up_data.neg_y);
		// depth_gain is 32 bits, so the depth quotient always fits
		z_val = up_data.word[dtp_pkg::LANE_Z][dtp_pkg::POINT_W-1:0];
		keep = (z_val >= cfg.depth_min) && (z_val <= cfg.depth_max);
	end

	assign up_ready = !valid_q || !pt_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			point_x   <= x_val;
			point_y   <= y_val;
			point_z   <= z_val;
			blue_out  <= up_data.blue;
			green_out <= up_data.green;
			red_out   <= up_data.red;
		end
	end

	assign pt_valid = valid_q;

endmodule

// File: rtl/disparity_to_point_converter.sv
// ----------------------------------------------------------------------------
// disparity_to_point_converter
// Triangulates a colored 3D point from one rectified pixel and its disparity.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock and keeps that rate as long as the output
// side takes beats; bubbles in the pipeline close up while the output is
// stalled. A beat passes a register for the offset from the principal point,
// one for the gain product, the chain of division cells (one quotient bit
// per cell, x, y and z side by side) and one for saturation, the depth
// window and the output register.
// Pixels with zero disparity or a depth outside the window give no result.
// Registers are written through the cfg channel, which is always ready, and
// are meant to change only while no pixel is in flight.
module disparity_to_point_converter (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dtp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dtp_pkg::CFG_DATA_W-1:0]       cfg_data,

	input  logic                                 pix_valid,
	output logic                                 pix_stall,
	input  logic [dtp_pkg::COORD_W-1:0]          column,
	input  logic [dtp_pkg::COORD_W-1:0]          row,
	input  logic [dtp_pkg::DISP_W-1:0]           disparity,
	input  logic [dtp_pkg::COLOR_W-1:0]          blue_in,
	input  logic [dtp_pkg::COLOR_W-1:0]          green_in,
	input  logic [dtp_pkg::COLOR_W-1:0]          red_in,

	output logic                                 pt_valid,
	input  logic                                 pt_stall,
	output logic signed [dtp_pkg::POINT_W-1:0]   point_x,
	output logic signed [dtp_pkg::POINT_W-1:0]   point_y,
	output logic        [dtp_pkg::POINT_W-1:0]   point_z,
	output logic        [dtp_pkg::COLOR_W-1:0]   blue_out,
	output logic        [dtp_pkg::COLOR_W-1:0]   green_out,
	output logic        [dtp_pkg::COLOR_W-1:0]   red_out
);

	dtp_pkg::cfg_t  cfg_q;
	dtp_pkg::pix_t  pix;
	logic           front_ready;

	logic           chain_valid [dtp_pkg::CELL_COUNT+1];
	logic           chain_ready [dtp_pkg::CELL_COUNT+1];
	dtp_pkg::cell_t chain_data  [dtp_pkg::CELL_COUNT+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x   <= dtp_pkg::CENTER_X_RST;
			cfg_q.center_y   <= dtp_pkg::CENTER_Y_RST;
			cfg_q.x_gain     <= dtp_pkg::GAIN_RST;
			cfg_q.y_gain     <= dtp_pkg::GAIN_RST;
			cfg_q.depth_gain <= dtp_pkg::GAIN_RST;
			cfg_q.depth_min  <= dtp_pkg::DEPTH_MIN_RST;
			cfg_q.depth_max  <= dtp_pkg::DEPTH_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dtp_pkg::REG_CENTER_X: begin
					cfg_q.center_x <= cfg_data[dtp_pkg::CENTER_W-1:0];
				end
				dtp_pkg::REG_CENTER_Y: begin
					cfg_q.center_y <= cfg_data[dtp_pkg::CENTER_W-1:0];
				end
				dtp_pkg::REG_X_GAIN: begin
					cfg_q.x_gain <= cfg_data;
				end
				dtp_pkg::REG_Y_GAIN: begin
					cfg_q.y_gain <= cfg_data;
				end
				dtp_pkg::REG_DEPTH_GAIN: begin
					cfg_q.depth_gain <= cfg_data;
				end
				dtp_pkg::REG_DEPTH_MIN: begin
					cfg_q.depth_min <= cfg_data;
				end
				dtp_pkg::REG_DEPTH_MAX: begin
					cfg_q.depth_max <= cfg_data;
				end
				default: begin
					// unmapped index, write dropped
				end
			endcase
		end
	end

	assign pix.column    = column;
	assign pix.row       = row;
	assign pix.disparity = disparity;
	assign pix.blue      = blue_in;
	assign pix.green     = green_in;
	assign pix.red       = red_in;

	assign pix_stall = !front_ready;

	dtp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.up_valid (pix_valid),
		.up_ready (front_ready),
		.up_data  (pix),
		.dn_valid (chain_valid[0]),
		.dn_ready (chain_ready[0]),
		.dn_data  (chain_data[0])
	);

	for (genvar i = 0; i < dtp_pkg::CELL_COUNT; i++) begin : g_cell
		dtp_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_valid[i]),
			.up_ready (chain_ready[i]),
			.up_data  (chain_data[i]),
			.dn_valid (chain_valid[i+1]),
			.dn_ready (chain_ready[i+1]),
			.dn_data  (chain_data[i+1])
		);
	end

	dtp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.up_valid  (chain_valid[dtp_pkg::CELL_COUNT]),
		.up_ready  (chain_ready[dtp_pkg::CELL_COUNT]),
		.up_data   (chain_data[dtp_pkg::CELL_COUNT]),
		.pt_valid  (pt_valid),
		.pt_stall  (pt_stall),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.blue_out  (blue_out),
		.green_out (green_out),
		.red_out   (red_out)
	);

endmodule

// File: bench/disparity_to_point_converter_tb.sv
// ----------------------------------------------------------------------------
// disparity_to_point_converter_tb
// Streams pixels into the converter with random gaps, while random stalls hold
// up the point side. Registers are reprogrammed between bursts, at the
// extremes and at random. Every point is compared field by field against a
// triangulation computed in the bench.
// ----------------------------------------------------------------------------
module disparity_to_point_converter_tb;
	import dtp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
	localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
	localparam int          DRAIN_CYCLES = 64;
	localparam int          IDLE_LIMIT   = 2000;
	localparam int          PHASE_BEATS  = 128;
	localparam int          PHASES       = 12;

	typedef struct packed {
		logic signed [POINT_W-1:0] x;
		logic signed [POINT_W-1:0] y;
		logic [POINT_W-1:0]        z;
		logic [COLOR_W-1:0]        blue;
		logic [COLOR_W-1:0]        green;
		logic [COLOR_W-1:0]        red;
	} point_t;

	class point_scoreboard;
		cfg_t   regs;
		point_t expected_q[$];
		int     errors;

		function void reset_regs();
			regs.center_x   = CENTER_X_RST;
			regs.center_y   = CENTER_Y_RST;
			regs.x_gain     = GAIN_RST;
			regs.y_gain     = GAIN_RST;
			regs.depth_gain = GAIN_RST;
			regs.depth_min  = DEPTH_MIN_RST;
			regs.depth_max  = DEPTH_MAX_RST;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_CENTER_X:   regs.center_x   = data[CENTER_W-1:0];
				REG_CENTER_Y:   regs.center_y   = data[CENTER_W-1:0];
				REG_X_GAIN:     regs.x_gain     = data;
				REG_Y_GAIN:     regs.y_gain     = data;
				REG_DEPTH_GAIN: regs.depth_gain = data;
				REG_DEPTH_MIN:  regs.depth_min  = data;
				REG_DEPTH_MAX:  regs.depth_max  = data;
				default: ;
			endcase
		endfunction

		// gain * (coord*16 - center) / (16*disp), truncated toward zero, saturated
		function logic [POINT_W-1:0] project(logic [COORD_W-1:0] coord,
				logic [CENTER_W-1:0] center, logic [GAIN_W-1:0] gain,
				logic [DISP_W-1:0] disp);
			logic [63:0] scaled;
			logic [63:0] mag;
			logic [63:0] q;
			logic        neg;
			scaled = {52'd0, coord};
			if (scaled >= 64'(MAX_IMAGE_SIDE))
				scaled = 64'(MAX_IMAGE_SIDE - 1);
			scaled = scaled << SUB_BITS;
			neg = scaled < {48'd0, center};
			mag = neg ? {48'd0, center} - scaled : scaled - {48'd0, center};
			q = ({32'd0, gain} * mag) / ({56'd0, disp} << SUB_BITS);
			if (!neg) begin
				if (q > 64'h7FFF_FFFF)
					q = 64'h7FFF_FFFF;
				return q[31:0];
			end
			if (q > 64'h8000_0000)
				q = 64'h8000_0000;
			return ~q[31:0] + 32'd1;
		endfunction

		function void note_pixel(pix_t p);
			point_t             pt;
			logic [POINT_W-1:0] depth;
			if (p.disparity == '0)
				return;
			depth = regs.depth_gain / {24'd0, p.disparity};
			if (depth < regs.depth_min || depth > regs.depth_max)
				return;
			pt.x     = project(p.column, regs.center_x, regs.x_gain, p.disparity);
			pt.y     = project(p.row, regs.center_y, regs.y_gain, p.disparity);
			pt.z     = depth;
			pt.blue  = p.blue;
			pt.green = p.green;
			pt.red   = p.red;
			expected_q = {expected_q, pt};
		endfunction

		function void note_error(string what, logic [31:0] want, logic [31:0] got);
			errors++;
			if (errors <= 10)
				$display("mismatch on %s: expected %h, got %h", what, want, got);
		endfunction

		function void check_point(point_t got);
			point_t want;
			if (expected_q.size() == 0) begin
				note_error("point with none expected", '0, got.z);
				return;
			end
			want = expected_q.pop_front();
			if (got.x !== want.x)         note_error("point_x", want.x, got.x);
			if (got.y !== want.y)         note_error("point_y", want.y, got.y);
			if (got.z !== want.z)         note_error("point_z", want.z, got.z);
			if (got.blue !== want.blue)   note_error("blue_out", want.blue, got.blue);
			if (got.green !== want.green) note_error("green_out", want.green, got.green);
			if (got.red !== want.red)     note_error("red_out", want.red, got.red);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic pix_valid;
	logic pix_stall;
	logic [COORD_W-1:0] column;
	logic [COORD_W-1:0] row;
	logic [DISP_W-1:0]  disparity;
	logic [COLOR_W-1:0] blue_in;
	logic [COLOR_W-1:0] green_in;
	logic [COLOR_W-1:0] red_in;
	logic pt_valid;
	logic pt_stall;
	logic signed [POINT_W-1:0] point_x;
	logic signed [POINT_W-1:0] point_y;
	logic [POINT_W-1:0] point_z;
	logic [COLOR_W-1:0] blue_out;
	logic [COLOR_W-1:0] green_out;
	logic [COLOR_W-1:0] red_out;

	point_scoreboard point_sb;
	bit calm;
	bit quiet;
	int idle_cycles = 0;

	disparity_to_point_converter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.column    (column),
		.row       (row),
		.disparity (disparity),
		.blue_in   (blue_in),
		.green_in  (green_in),
		.red_in    (red_in),
		.pt_valid  (pt_valid),
		.pt_stall  (pt_stall),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.blue_out  (blue_out),
		.green_out (green_out),
		.red_out   (red_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CENTER_W-1:0] pick_center();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return CENTER_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return ALL_ONES;
			2: return $urandom_range(32'h0000_4000, 32'h0040_0000);
			default: return $urandom;
		endcase
	endfunction

	// extremes, the principal point and its neighbors, or anywhere
	function automatic logic [COORD_W-1:0] pick_coord(logic [CENTER_W-1:0] center);
		int c;
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: begin
				c = int'(center >> SUB_BITS) + int'($urandom_range(0, 2)) - 1;
				if (c < 0)
					c = 0;
				if (c > MAX_IMAGE_SIDE - 1)
					c = MAX_IMAGE_SIDE - 1;
				return c[COORD_W-1:0];
			end
			default: return COORD_W'($urandom_range(0, MAX_IMAGE_SIDE - 1));
		endcase
	endfunction

	always @(posedge clk) begin : monitor
		pix_t   seen_pix;
		point_t seen_pt;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				point_sb.write_reg(cfg_index, cfg_data);
			if (pix_valid && !pix_stall) begin
				seen_pix.column    = column;
				seen_pix.row       = row;
				seen_pix.disparity = disparity;
				seen_pix.blue      = blue_in;
				seen_pix.green     = green_in;
				seen_pix.red       = red_in;
				point_sb.note_pixel(seen_pix);
			end
			if (pt_valid && !pt_stall) begin
				seen_pt.x     = point_x;
				seen_pt.y     = point_y;
				seen_pt.z     = point_z;
				seen_pt.blue  = blue_out;
				seen_pt.green = green_out;
				seen_pt.red   = red_out;
				point_sb.check_point(seen_pt);
			end
		end
	end

	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (pix_valid && !pix_stall) || (pt_valid && !pt_stall))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : point_backpressure
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (quiet || calm) begin
				pt_stall <= 1'b0;
				hold = 0;
			end else if (hold > 0)
				hold--;
			else if ($urandom_range(0, 2) == 0) begin
				pt_stall <= 1'b1;
				hold = idle_len();
			end else begin
				pt_stall <= 1'b0;
				hold = $urandom_range(0, 12);
			end
		end
	end

	// leaves cfg_valid high so back-to-back writes need no lowering
	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] rw,
			input logic [DISP_W-1:0] disp, input logic [COLOR_W-1:0] b, g, r);
		int gap;
		gap = calm ? 0 : ($urandom_range(0, 1) ? 0 : idle_len());
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_valid <= 1'b1;
		column    <= col;
		row       <= rw;
		disparity <= disp;
		blue_in   <= b;
		green_in  <= g;
		red_in    <= r;
		do @(posedge clk); while (pix_stall);
		@(negedge clk);
	endtask

	// dropped beats may still be in flight after the last point came out
	task automatic drain();
		pix_valid <= 1'b0;
		while (point_sb.expected_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
		quiet = 1'b1;
		repeat (DRAIN_CYCLES) @(negedge clk);
		quiet = 1'b0;
	endtask

	initial begin : stimulus
		int                 beats;
		logic [DISP_W-1:0]  disp;
		logic [DISP_W-1:0]  d_near;
		logic [DISP_W-1:0]  d_far;
		logic [DISP_W-1:0]  d_swap;
		logic [GAIN_W-1:0]  dgain;
		logic [POINT_W-1:0] lo;
		logic [POINT_W-1:0] hi;

		point_sb = new;
		point_sb.reset_regs();
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		pix_valid = 1'b0;
		column    = '0;
		row       = '0;
		disparity = '0;
		blue_in   = '0;
		green_in  = '0;
		red_in    = '0;
		pt_stall  = 1'b0;
		calm      = 1'b0;
		quiet     = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset centers and gains, with the near limit opened so points come out
		program_reg(REG_DEPTH_MIN, '0);
		cfg_valid <= 1'b0;
		send_pixel(100, 200, 0, 8'h01, 8'h02, 8'h03);
		send_pixel(0, 0, 1, 8'h00, 8'h00, 8'h00);
		send_pixel(4095, 4095, 255, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(320, 240, 7, 8'h55, 8'hAA, 8'h0F);
		send_pixel(319, 241, 3, 8'hAA, 8'h55, 8'hF0);
		send_pixel(4095, 0, 2, 8'h80, 8'h7F, 8'h01);

		// everything at its extreme, plus a write to an index that does not exist
		drain();
		program_reg(REG_CENTER_X, '0);
		program_reg(REG_CENTER_Y, ALL_ONES);
		program_reg(REG_X_GAIN, ALL_ONES);
		program_reg(REG_Y_GAIN, ALL_ONES);
		program_reg(REG_DEPTH_GAIN, ALL_ONES);
		program_reg(REG_NONE, '0);
		program_reg(REG_DEPTH_MIN, '0);
		program_reg(REG_DEPTH_MAX, ALL_ONES);
		cfg_valid <= 1'b0;
		send_pixel(4095, 0, 1, 8'h12, 8'h34, 8'h56);
		send_pixel(0, 4095, 255, 8'h9A, 8'hBC, 8'hDE);
		send_pixel(2048, 2048, 128, 8'hFE, 8'h01, 8'h80);
		send_pixel(0, 0, 0, 8'hFF, 8'hFF, 8'hFF);

		// saturation edges on x and both edges of the depth window
		drain();
		program_reg(REG_CENTER_X, 32'd16);
		program_reg(REG_CENTER_Y, 32'd16);
		program_reg(REG_X_GAIN, 32'h8000_0000);
		program_reg(REG_Y_GAIN, '0);
		program_reg(REG_DEPTH_GAIN, 32'd1000);
		program_reg(REG_DEPTH_MIN, 32'd100);
		program_reg(REG_DEPTH_MAX, 32'd1000);
		cfg_valid <= 1'b0;
		send_pixel(0, 1, 1, 8'h11, 8'h22, 8'h33);
		send_pixel(2, 1, 1, 8'h44, 8'h55, 8'h66);
		send_pixel(3, 1, 1, 8'h77, 8'h88, 8'h99);
		send_pixel(1, 1, 10, 8'hAA, 8'hBB, 8'hCC);
		send_pixel(0, 0, 11, 8'hDD, 8'hEE, 8'hFF);
		send_pixel(0, 0, 2, 8'h01, 8'h10, 8'h00);

		// depth beyond the far limit
		drain();
		program_reg(REG_DEPTH_MIN, 32'd500);
		program_reg(REG_DEPTH_MAX, 32'd999);
		cfg_valid <= 1'b0;
		send_pixel(5, 5, 1, 8'h0A, 8'h0B, 8'h0C);
		send_pixel(5, 5, 2, 8'h0D, 8'h0E, 8'h0F);

		// inverted window drops every point
		drain();
		program_reg(REG_DEPTH_MIN, ALL_ONES);
		program_reg(REG_DEPTH_MAX, '0);
		cfg_valid <= 1'b0;
		send_pixel(0, 0, 1, 8'h00, 8'hFF, 8'h00);
		send_pixel(4095, 4095, 255, 8'hFF, 8'h00, 8'hFF);
		send_pixel(7, 7, 3, 8'h5A, 8'hA5, 8'h3C);

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			calm = 1'b0;
			case ($urandom_range(0, 4))
				0: dgain = ALL_ONES;
				1: dgain = '0;
				2: dgain = $urandom_range(32'h0001_0000, 32'h0400_0000);
				default: dgain = $urandom;
			endcase
			d_near = DISP_W'($urandom_range(1, 255));
			d_far  = DISP_W'($urandom_range(1, 255));
			if (d_near > d_far) begin
				d_swap = d_near;
				d_near = d_far;
				d_far  = d_swap;
			end
			// a window between two disparities keeps its edges exactly reachable
			case ($urandom_range(0, 3))
				0: begin
					lo = '0;
					hi = ALL_ONES;
				end
				1: begin
					lo = dgain / {24'd0, d_far};
					hi = dgain / {24'd0, d_near};
				end
				2: begin
					lo = dgain / {24'd0, d_near};
					hi = lo;
				end
				default: begin
					lo = '0;
					hi = dgain / {24'd0, d_near};
				end
			endcase
			program_reg(REG_CENTER_X, CFG_DATA_W'(pick_center()));
			program_reg(REG_CENTER_Y, CFG_DATA_W'(pick_center()));
			program_reg(REG_X_GAIN, pick_gain());
			program_reg(REG_Y_GAIN, pick_gain());
			program_reg(REG_DEPTH_GAIN, dgain);
			if ($urandom_range(0, 2) == 0)
				program_reg(REG_NONE, $urandom);
			program_reg(REG_DEPTH_MIN, lo);
			program_reg(REG_DEPTH_MAX, hi);
			cfg_valid <= 1'b0;

			calm = ($urandom_range(0, 3) == 0);
			beats = 0;
			while (beats < PHASE_BEATS) begin
				case ($urandom_range(0, 19))
					0, 1: disp = '0;
					2: disp = 8'd1;
					3: disp = 8'd255;
					4: disp = DISP_W'($urandom_range(1, 4));
					5: disp = $urandom_range(0, 1) ? d_near : d_far;
					default: disp = DISP_W'($urandom_range(1, 255));
				endcase
				beats++;
				send_pixel(pick_coord(point_sb.regs.center_x),
					pick_coord(point_sb.regs.center_y), disp,
					COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)),
					COLOR_W'($urandom_range(0, 255)));
			end
		end

		calm = 1'b0;
		drain();
		if (point_sb.errors == 0 && point_sb.expected_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: sim.f
rtl/dtp_pkg.sv
rtl/dtp_front.sv
rtl/dtp_cell.sv
rtl/dtp_back.sv
rtl/disparity_to_point_converter.sv
bench/disparity_to_point_converter_tb.sv
